// ----- rtl/core/json_token_structure_parser_macros.svh -----
// Assertion macros shared by the parser modules.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef JSON_TOKEN_STRUCTURE_PARSER_MACROS_SVH
`define JSON_TOKEN_STRUCTURE_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JTSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JTSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/jtsp_pkg.sv -----
package jtsp_pkg;

  // Token kinds.
  localparam logic [3:0] TOK_EOF       = 4'd0;
  localparam logic [3:0] TOK_STRING    = 4'd6;
  localparam logic [3:0] TOK_OPEN_ARR  = 4'd7;
  localparam logic [3:0] TOK_CLOSE_ARR = 4'd8;
  localparam logic [3:0] TOK_OPEN_OBJ  = 4'd9;
  localparam logic [3:0] TOK_CLOSE_OBJ = 4'd10;
  localparam logic [3:0] TOK_COMMA     = 4'd11;
  localparam logic [3:0] TOK_COLON     = 4'd12;

  // Input actions.
  localparam logic ACT_FEED    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_MORE     = 2'd0;
  localparam logic [1:0] ST_DONE     = 2'd1;
  localparam logic [1:0] ST_SYNTAX   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // Structural events.
  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_SCALAR    = 4'd1;
  localparam logic [3:0] EV_KEY       = 4'd2;
  localparam logic [3:0] EV_EMPTY_ARR = 4'd3;
  localparam logic [3:0] EV_EMPTY_OBJ = 4'd4;
  localparam logic [3:0] EV_OPEN_ARR  = 4'd5;
  localparam logic [3:0] EV_OPEN_OBJ  = 4'd6;
  localparam logic [3:0] EV_CLOSE_ARR = 4'd7;
  localparam logic [3:0] EV_CLOSE_OBJ = 4'd8;

  // Input beat.
  typedef struct packed {
    logic       action;
    logic [3:0] token_kind;
  } jtsp_in_t;

  // Output beat.
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  event_res;
    logic [15:0] element_count;
    logic [5:0]  nesting_depth;
  } jtsp_out_t;

  // Stack command broadcast to the row of level cells.
  typedef struct packed {
    logic push;
    logic pop;
    logic bump;
    logic push_obj;
  } jtsp_stack_cmd_t;

endpackage

// ----- rtl/core/jtsp_cell.sv -----
module jtsp_cell
  import jtsp_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  jtsp_stack_cmd_t       cmd,
  input  logic                  up_obj,
  input  logic [COUNT_BITS-1:0] up_count,
  input  logic                  down_obj,
  input  logic [COUNT_BITS-1:0] down_count,
  output logic                  obj,
  output logic [COUNT_BITS-1:0] count
);

  // One nesting level: a push shifts the level above in, a pop shifts the
  // level below in, and a bump advances the element count with saturation.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      obj   <= up_obj;
      count <= up_count;
    end else if (cmd.pop) begin
      obj   <= down_obj;
      count <= down_count;
    end else if (cmd.bump && (count != {COUNT_BITS{1'b1}})) begin
      count <= count + COUNT_BITS'(1);
    end
  end

endmodule

// ----- rtl/core/jtsp_ctrl.sv -----
`include "json_token_structure_parser_macros.svh"

module jtsp_ctrl
  import jtsp_pkg::*;
#(
  parameter int MAX_DEPTH  = 32,
  parameter int COUNT_BITS = 16,
  localparam int TOP_W     = $clog2(MAX_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  jtsp_in_t              in_beat,
  input  logic [5:0]            depth_limit,
  input  logic                  top_obj,
  input  logic [COUNT_BITS-1:0] top_count,
  input  logic                  second_obj,
  output jtsp_stack_cmd_t       stack_cmd,
  output jtsp_out_t             result
);

  localparam int CMP_W = (TOP_W > 6) ? TOP_W : 6;

  // Parse modes.
  localparam logic [2:0] M_VALUE     = 3'd0;
  localparam logic [2:0] M_FIRST_ARR = 3'd1;
  localparam logic [2:0] M_NEXT_ARR  = 3'd2;
  localparam logic [2:0] M_FIRST_KV  = 3'd3;
  localparam logic [2:0] M_KV_COLON  = 3'd4;
  localparam logic [2:0] M_KV_END    = 3'd5;
  localparam logic [2:0] M_NEXT_KV   = 3'd6;
  localparam logic [2:0] M_FINISH    = 3'd7;

  logic [2:0]      mode, mode_next;
  logic [TOP_W-1:0] stack_top, stack_top_next;
  logic            done_flag, done_flag_next;
  logic            error_flag, error_flag_next;
  logic            can_push;
  logic            tok_is_value;
  logic [1:0]      st;
  logic [3:0]      ev;
  logic [15:0]     cnt;
  jtsp_stack_cmd_t cmd;
  logic [3:0]      tok;

  assign tok = in_beat.token_kind;

  // A push is allowed below both the configured limit and the cell count.
  assign can_push = (CMP_W'(stack_top) < CMP_W'(depth_limit)) &&
                    (stack_top < TOP_W'(MAX_DEPTH));

  // Tokens that may start a value.
  assign tok_is_value = (tok <= TOK_STRING) || (tok == TOK_OPEN_ARR) ||
                        (tok == TOK_OPEN_OBJ);

  // Next-state decode for one token.
  always_comb begin
    mode_next       = mode;
    stack_top_next  = stack_top;
    done_flag_next  = done_flag;
    error_flag_next = error_flag;
    st  = ST_MORE;
    ev  = EV_NONE;
    cnt = '0;
    cmd = '0;
    if (in_beat.action == ACT_RESTART) begin
      mode_next       = M_VALUE;
      stack_top_next  = '0;
      done_flag_next  = 1'b0;
      error_flag_next = 1'b0;
    end else if (error_flag || done_flag || (mode == M_FINISH)) begin
      st = ST_SYNTAX;
    end else begin
      unique case (mode)
        M_VALUE: begin
          if (tok == TOK_OPEN_ARR) begin
            mode_next = M_FIRST_ARR;
            ev        = EV_OPEN_ARR;
          end else if (tok == TOK_OPEN_OBJ) begin
            mode_next = M_FIRST_KV;
            ev        = EV_OPEN_OBJ;
          end else if (tok > TOK_STRING) begin
            st = ST_SYNTAX;
          end else begin
            ev = (tok == TOK_EOF) ? EV_NONE : EV_SCALAR;
            if (stack_top == '0) begin
              mode_next      = M_FINISH;
              done_flag_next = 1'b1;
              st             = ST_DONE;
            end else begin
              mode_next = top_obj ? M_KV_END : M_NEXT_ARR;
            end
          end
        end
        M_FIRST_ARR: begin
          if (tok == TOK_CLOSE_ARR) begin
            ev = EV_EMPTY_ARR;
            if (stack_top == '0) begin
              mode_next      = M_FINISH;
              done_flag_next = 1'b1;
              st             = ST_DONE;
            end else begin
              mode_next = top_obj ? M_KV_END : M_NEXT_ARR;
            end
          end else if (!tok_is_value) begin
            st = ST_SYNTAX;
          end else if (!can_push) begin
            st = ST_OVERFLOW;
          end else begin
            // The first element opens a new array level.
            cmd.push       = 1'b1;
            cmd.push_obj   = 1'b0;
            stack_top_next = stack_top + TOP_W'(1);
            if (tok == TOK_OPEN_ARR) begin
              mode_next = M_FIRST_ARR;
              ev        = EV_OPEN_ARR;
            end else if (tok == TOK_OPEN_OBJ) begin
              mode_next = M_FIRST_KV;
              ev        = EV_OPEN_OBJ;
            end else begin
              ev        = (tok == TOK_EOF) ? EV_NONE : EV_SCALAR;
              mode_next = M_NEXT_ARR;
            end
          end
        end
        M_NEXT_ARR: begin
          if ((tok == TOK_CLOSE_ARR) && (stack_top != '0)) begin
            cmd.pop        = 1'b1;
            stack_top_next = stack_top - TOP_W'(1);
            cnt            = 16'(top_count);
            ev             = EV_CLOSE_ARR;
            if (stack_top == TOP_W'(1)) begin
              mode_next      = M_FINISH;
              done_flag_next = 1'b1;
              st             = ST_DONE;
            end else begin
              mode_next = second_obj ? M_KV_END : M_NEXT_ARR;
            end
          end else if (tok == TOK_COMMA) begin
            cmd.bump  = (stack_top != '0);
            mode_next = M_VALUE;
          end else begin
            st = ST_SYNTAX;
          end
        end
        M_FIRST_KV: begin
          if (tok == TOK_CLOSE_OBJ) begin
            ev = EV_EMPTY_OBJ;
            if (stack_top == '0) begin
              mode_next      = M_FINISH;
              done_flag_next = 1'b1;
              st             = ST_DONE;
            end else begin
              mode_next = top_obj ? M_KV_END : M_NEXT_ARR;
            end
          end else if (tok != TOK_STRING) begin
            st = ST_SYNTAX;
          end else if (!can_push) begin
            st = ST_OVERFLOW;
          end else begin
            cmd.push       = 1'b1;
            cmd.push_obj   = 1'b1;
            stack_top_next = stack_top + TOP_W'(1);
            ev             = EV_KEY;
            mode_next      = M_KV_COLON;
          end
        end
        M_KV_COLON: begin
          if (tok == TOK_COLON) begin
            mode_next = M_VALUE;
          end else begin
            st = ST_SYNTAX;
          end
        end
        M_KV_END: begin
          if ((tok == TOK_CLOSE_OBJ) && (stack_top != '0)) begin
            cmd.pop        = 1'b1;
            stack_top_next = stack_top - TOP_W'(1);
            cnt            = 16'(top_count);
            ev             = EV_CLOSE_OBJ;
            if (stack_top == TOP_W'(1)) begin
              mode_next      = M_FINISH;
              done_flag_next = 1'b1;
              st             = ST_DONE;
            end else begin
              mode_next = second_obj ? M_KV_END : M_NEXT_ARR;
            end
          end else if (tok == TOK_COMMA) begin
            mode_next = M_NEXT_KV;
          end else begin
            st = ST_SYNTAX;
          end
        end
        M_NEXT_KV: begin
          if (tok == TOK_STRING) begin
            cmd.bump  = (stack_top != '0);
            ev        = EV_KEY;
            mode_next = M_KV_COLON;
          end else begin
            st = ST_SYNTAX;
          end
        end
        default: begin
          st = ST_SYNTAX;
        end
      endcase
      // Any error freezes the state and sets the sticky flag.
      if ((st == ST_SYNTAX) || (st == ST_OVERFLOW)) begin
        mode_next       = mode;
        stack_top_next  = stack_top;
        done_flag_next  = done_flag;
        error_flag_next = 1'b1;
        ev              = EV_NONE;
        cnt             = '0;
        cmd             = '0;
      end
    end
  end

  // Result for the current beat and the gated stack command.
  always_comb begin
    result.status        = st;
    result.event_res     = ev;
    result.element_count = cnt;
    result.nesting_depth = 6'(stack_top_next);
    stack_cmd            = fire ? cmd : '0;
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_VALUE;
      stack_top  <= '0;
      done_flag  <= 1'b0;
      error_flag <= 1'b0;
    end else if (fire) begin
      mode       <= mode_next;
      stack_top  <= stack_top_next;
      done_flag  <= done_flag_next;
      error_flag <= error_flag_next;
    end
  end

  `JTSP_ASSERT_SAME(a_done_means_finish, done_flag, mode == M_FINISH, "done without finish mode")
  `JTSP_ASSERT_SAME(a_pop_nonempty, stack_cmd.pop, stack_top != '0, "pop on an empty stack")
  `JTSP_ASSERT_SAME(a_push_room, stack_cmd.push, stack_top < TOP_W'(MAX_DEPTH), "push on a full stack")

endmodule

// ----- rtl/core/json_token_structure_parser.sv -----
// JSON token structure parser.
// Input channel in_valid/in_ready/in_data carries one token kind or a restart
// per beat. Output channel out_valid/out_ready/out_data returns exactly one
// result beat per input beat: status, structural event, the element count of
// a container just closed, and the nesting depth after the token.
// Throughput is one token per cycle while the receiver takes results: the top
// of stack sits in the head cell of a row of level cells, so each token needs
// only that cell and one shift of the row. The depth limit is written through
// cfg_we/cfg_wdata; the user must do so only while the block is idle, and the
// block itself does not enforce it. Reset clears the parse mode, depth, done
// and error flags and sets the depth limit to 32; the level cells need no
// clearing since only pushed levels are read. When the receiver stalls, the
// result stays in the output register and in_ready stays low until it is
// taken; a new token is accepted in the same cycle the held result leaves.
`include "json_token_structure_parser_macros.svh"

module json_token_structure_parser
  import jtsp_pkg::*;
#(
  parameter int MAX_DEPTH  = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  jtsp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output jtsp_out_t out_data,
  input  logic      cfg_we,
  input  logic [5:0] cfg_wdata
);

  logic                  fire;
  logic [5:0]            depth_limit;
  jtsp_stack_cmd_t       stack_cmd;
  jtsp_stack_cmd_t       head_cmd;
  jtsp_stack_cmd_t       tail_cmd;
  jtsp_out_t             result;
  logic                  cell_obj   [MAX_DEPTH];
  logic [COUNT_BITS-1:0] cell_count [MAX_DEPTH];
  logic                  second_obj;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  // Depth limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= 6'd32;
    end else if (cfg_we) begin
      depth_limit <= cfg_wdata;
    end
  end

  jtsp_ctrl #(
    .MAX_DEPTH  (MAX_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .in_beat     (in_data),
    .depth_limit (depth_limit),
    .top_obj     (cell_obj[0]),
    .top_count   (cell_count[0]),
    .second_obj  (second_obj),
    .stack_cmd   (stack_cmd),
    .result      (result)
  );

  // Only the head cell counts elements.
  always_comb begin
    head_cmd      = stack_cmd;
    tail_cmd      = stack_cmd;
    tail_cmd.bump = 1'b0;
  end

  // Row of level cells, head cell at index zero.
  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    logic                  up_obj;
    logic [COUNT_BITS-1:0] up_count;
    logic                  down_obj;
    logic [COUNT_BITS-1:0] down_count;

    if (i == 0) begin : g_head
      assign up_obj   = stack_cmd.push_obj;
      assign up_count = COUNT_BITS'(1);
    end else begin : g_inner
      assign up_obj   = cell_obj[i-1];
      assign up_count = cell_count[i-1];
    end

    if (i == MAX_DEPTH - 1) begin : g_tail
      assign down_obj   = 1'b0;
      assign down_count = '0;
    end else begin : g_body
      assign down_obj   = cell_obj[i+1];
      assign down_count = cell_count[i+1];
    end

    jtsp_cell #(
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk        (clk),
      .cmd        ((i == 0) ? head_cmd : tail_cmd),
      .up_obj     (up_obj),
      .up_count   (up_count),
      .down_obj   (down_obj),
      .down_count (down_count),
      .obj        (cell_obj[i]),
      .count      (cell_count[i])
    );
  end

  // Kind of the level under the top, needed after a pop.
  if (MAX_DEPTH > 1) begin : g_second
    assign second_obj = cell_obj[1];
  end else begin : g_no_second
    assign second_obj = 1'b0;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

  `JTSP_ASSERT_NEXT(a_restart_clears, fire && (in_data.action == ACT_RESTART), (out_data.nesting_depth == 6'd0) && (out_data.status == ST_MORE), "restart result not cleared")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import jtsp_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 6;
  localparam int MAX_DEPTH = 32;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam int PHASES = 8;
  localparam int BEATS_PER_PHASE = 150;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  // Token kinds that the package leaves unnamed.
  localparam logic [3:0] TOK_NULL = 4'd1;
  localparam logic [3:0] TOK_TRUE = 4'd2;
  localparam logic [3:0] TOK_INT = 4'd4;
  localparam logic [3:0] TOK_RESERVED_LO = 4'd13;
  localparam logic [3:0] TOK_RESERVED_HI = 4'd15;

  typedef enum logic [2:0] {
    MODE_VALUE,
    MODE_FIRST_ARR,
    MODE_NEXT_ARR,
    MODE_FIRST_KEY,
    MODE_KEY_COLON,
    MODE_PAIR_END,
    MODE_NEXT_KEY,
    MODE_FINISHED
  } parse_mode_e;

  typedef enum logic [1:0] {
    READY_STEADY,
    READY_ALTERNATE,
    READY_RANDOM
  } ready_style_e;

  // Structure tracker for the token stream plus the queue of results it owes.
  class json_structure_scoreboard;
    logic [5:0] depth_limit;
    parse_mode_e mode;
    bit is_object [MAX_DEPTH];
    logic [15:0] elem_count [MAX_DEPTH];
    int unsigned depth;
    bit finished;
    bit failed;
    jtsp_out_t results_due [$];
    int unsigned failures;

    function new();
      depth_limit = 6'd32;
      mode = MODE_VALUE;
      depth = 0;
      finished = 1'b0;
      failed = 1'b0;
      failures = 0;
    endfunction

    // A value just ended: either the document is done or we return to the
    // enclosing container.
    function logic [1:0] value_complete();
      if (depth == 0) begin
        mode = MODE_FINISHED;
        finished = 1'b1;
        return ST_DONE;
      end
      mode = is_object[depth - 1] ? MODE_PAIR_END : MODE_NEXT_ARR;
      return ST_MORE;
    endfunction

    function logic [1:0] take_value(logic [3:0] tok, output logic [3:0] ev);
      ev = EV_NONE;
      if (tok == TOK_OPEN_ARR) begin
        mode = MODE_FIRST_ARR;
        ev = EV_OPEN_ARR;
        return ST_MORE;
      end
      if (tok == TOK_OPEN_OBJ) begin
        mode = MODE_FIRST_KEY;
        ev = EV_OPEN_OBJ;
        return ST_MORE;
      end
      if (tok > TOK_STRING) return ST_SYNTAX;
      // An end-of-file token stands for an empty value.
      ev = (tok == TOK_EOF) ? EV_NONE : EV_SCALAR;
      return value_complete();
    endfunction

    function bit push_level(bit obj);
      int unsigned cap;
      cap = (depth_limit > MAX_DEPTH) ? MAX_DEPTH : depth_limit;
      if (depth >= cap || depth >= MAX_DEPTH) return 1'b0;
      is_object[depth] = obj;
      elem_count[depth] = 16'd1;
      depth++;
      return 1'b1;
    endfunction

    function void bump_count();
      if (depth == 0) return;
      if (elem_count[depth - 1] != COUNT_MAX) elem_count[depth - 1]++;
    endfunction

    // Advance the tracker by one beat and return the result it must produce.
    function jtsp_out_t next_result(jtsp_in_t beat);
      jtsp_out_t res;
      logic [3:0] tok;
      tok = beat.token_kind;
      res = '0;
      if (beat.action == ACT_RESTART) begin
        mode = MODE_VALUE;
        depth = 0;
        finished = 1'b0;
        failed = 1'b0;
      end else if (failed || finished || mode == MODE_FINISHED) begin
        res.status = ST_SYNTAX;
      end else begin
        case (mode)
          MODE_VALUE: res.status = take_value(tok, res.event_res);
          MODE_FIRST_ARR: begin
            // A non-value token is rejected before the depth is checked.
            if (tok == TOK_CLOSE_ARR) begin
              res.event_res = EV_EMPTY_ARR;
              res.status = value_complete();
            end else if (tok > TOK_STRING && tok != TOK_OPEN_ARR && tok != TOK_OPEN_OBJ) begin
              res.status = ST_SYNTAX;
            end else if (!push_level(1'b0)) begin
              res.status = ST_OVERFLOW;
            end else begin
              res.status = take_value(tok, res.event_res);
            end
          end
          MODE_NEXT_ARR: begin
            if (tok == TOK_CLOSE_ARR && depth > 0) begin
              depth--;
              res.element_count = elem_count[depth];
              res.event_res = EV_CLOSE_ARR;
              res.status = value_complete();
            end else if (tok == TOK_COMMA) begin
              bump_count();
              mode = MODE_VALUE;
            end else begin
              res.status = ST_SYNTAX;
            end
          end
          MODE_FIRST_KEY: begin
            if (tok == TOK_CLOSE_OBJ) begin
              res.event_res = EV_EMPTY_OBJ;
              res.status = value_complete();
            end else if (tok != TOK_STRING) begin
              res.status = ST_SYNTAX;
            end else if (!push_level(1'b1)) begin
              res.status = ST_OVERFLOW;
            end else begin
              res.event_res = EV_KEY;
              mode = MODE_KEY_COLON;
            end
          end
          MODE_KEY_COLON: begin
            if (tok == TOK_COLON) mode = MODE_VALUE;
            else res.status = ST_SYNTAX;
          end
          MODE_PAIR_END: begin
            if (tok == TOK_CLOSE_OBJ && depth > 0) begin
              depth--;
              res.element_count = elem_count[depth];
              res.event_res = EV_CLOSE_OBJ;
              res.status = value_complete();
            end else if (tok == TOK_COMMA) begin
              mode = MODE_NEXT_KEY;
            end else begin
              res.status = ST_SYNTAX;
            end
          end
          MODE_NEXT_KEY: begin
            if (tok == TOK_STRING) begin
              bump_count();
              res.event_res = EV_KEY;
              mode = MODE_KEY_COLON;
            end else begin
              res.status = ST_SYNTAX;
            end
          end
          default: res.status = ST_SYNTAX;
        endcase
        // Errors stick until the next restart and carry no event.
        if (res.status == ST_SYNTAX || res.status == ST_OVERFLOW) begin
          failed = 1'b1;
          res.event_res = EV_NONE;
          res.element_count = '0;
        end
      end
      res.nesting_depth = 6'(depth);
      return res;
    endfunction

    function void note_token(jtsp_in_t beat);
      results_due.push_back(next_result(beat));
    endfunction

    function void check_result(jtsp_out_t got);
      jtsp_out_t want;
      if (results_due.size() == 0) begin
        $error("result beat %h arrived with no token outstanding", got);
        failures++;
        return;
      end
      want = results_due.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        failures++;
      end
      if (got.event_res !== want.event_res) begin
        $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
        failures++;
      end
      if (got.element_count !== want.element_count) begin
        $error("element_count: expected %0d, got %0d", want.element_count, got.element_count);
        failures++;
      end
      if (got.nesting_depth !== want.nesting_depth) begin
        $error("nesting_depth: expected %0d, got %0d", want.nesting_depth, got.nesting_depth);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  jtsp_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  jtsp_out_t out_data;
  logic cfg_we = 1'b0;
  logic [5:0] cfg_wdata = '0;

  json_structure_scoreboard sb = new();
  // Second tracker that runs ahead of the block to steer token generation.
  json_structure_scoreboard walker = new();

  int unsigned dive_depth = 0;
  bit noisy_doc = 1'b0;
  bit long_hold_req = 1'b0;
  int unsigned quiet_cycles = 0;

  json_token_structure_parser dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Sample both channels at each edge: note tokens, check results, watch for a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_token(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // The receiver cycles through steady, alternating and random ready patterns,
  // and on request holds off for a long stretch so the block backs up.
  initial begin : receiver
    ready_style_e style;
    int unsigned span;
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end else begin
        style = ready_style_e'($urandom_range(0, 2));
        span = $urandom_range(4, 48);
        for (int c = 0; c < span; c++) begin
          case (style)
            READY_STEADY: out_ready <= 1'b1;
            READY_ALTERNATE: out_ready <= c[0];
            default: out_ready <= ($urandom_range(0, 9) < 6);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  function automatic jtsp_in_t token_beat(logic act, logic [3:0] tok);
    jtsp_in_t b;
    b.action = act;
    b.token_kind = tok;
    return b;
  endfunction

  // Deep dives open containers eagerly until the target depth is reached.
  function automatic logic [3:0] value_token();
    int unsigned open_pct;
    open_pct = (walker.depth < dive_depth) ? 65 : 8;
    if ($urandom_range(0, 99) < open_pct)
      return $urandom_range(0, 1) ? TOK_OPEN_ARR : TOK_OPEN_OBJ;
    return 4'($urandom_range(TOK_EOF, TOK_STRING));
  endfunction

  // Pick a token that the grammar accepts in the walker's current mode.
  function automatic logic [3:0] shaped_token();
    int unsigned roll;
    int unsigned close_pct;
    roll = $urandom_range(0, 99);
    close_pct = (walker.depth < dive_depth) ? 20 : 45;
    case (walker.mode)
      MODE_VALUE: return value_token();
      MODE_FIRST_ARR: return (roll < 12) ? TOK_CLOSE_ARR : value_token();
      MODE_NEXT_ARR: return (roll < close_pct) ? TOK_CLOSE_ARR : TOK_COMMA;
      MODE_FIRST_KEY: return (roll < 12) ? TOK_CLOSE_OBJ : TOK_STRING;
      MODE_KEY_COLON: return TOK_COLON;
      MODE_PAIR_END: return (roll < close_pct) ? TOK_CLOSE_OBJ : TOK_COMMA;
      MODE_NEXT_KEY: return TOK_STRING;
      default: return TOK_EOF;
    endcase
  endfunction

  // Mostly well-formed documents; a share of them are noisy, with random
  // tokens and restarts in the middle.
  function automatic jtsp_in_t next_token();
    jtsp_in_t b;
    int unsigned cap;
    b.action = ACT_FEED;
    b.token_kind = 4'($urandom_range(0, 15));
    if (walker.failed || walker.finished) begin
      if ($urandom_range(0, 9) < 8) b.action = ACT_RESTART;
    end else if (noisy_doc && $urandom_range(0, 99) < 3) begin
      b.action = ACT_RESTART;
    end else if (!(noisy_doc && $urandom_range(0, 99) < 8)) begin
      b.token_kind = shaped_token();
    end
    if (b.action == ACT_RESTART) begin
      cap = (walker.depth_limit > MAX_DEPTH) ? MAX_DEPTH : walker.depth_limit;
      noisy_doc = ($urandom_range(0, 9) < 3);
      dive_depth = ($urandom_range(0, 4) == 0) ? cap + 1 : $urandom_range(0, 3);
    end
    void'(walker.next_result(b));
    if (walker.depth >= dive_depth) dive_depth = 0;
    return b;
  endfunction

  // Present one beat and hold it until the block takes it.
  task automatic offer(jtsp_in_t beat);
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.results_due.size() != 0);
  endtask

  // Change the depth limit only once the block has gone quiet.
  task automatic write_depth_limit(logic [5:0] value);
    drain_results();
    repeat (2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.depth_limit = value;
    walker.depth_limit = value;
  endtask

  initial begin
    jtsp_in_t opening [$];
    logic [5:0] limit_plan [PHASES];
    int unsigned burst_left;
    bit bursty;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed opening at the reset depth limit.
    opening = {
      // Array with a comma, closed with count two.
      token_beat(ACT_FEED, TOK_OPEN_ARR), token_beat(ACT_FEED, TOK_INT),
      token_beat(ACT_FEED, TOK_COMMA), token_beat(ACT_FEED, TOK_TRUE),
      token_beat(ACT_FEED, TOK_CLOSE_ARR),
      // Empty object, then a token after the document finished.
      token_beat(ACT_RESTART, TOK_EOF),
      token_beat(ACT_FEED, TOK_OPEN_OBJ), token_beat(ACT_FEED, TOK_CLOSE_OBJ),
      token_beat(ACT_FEED, TOK_NULL),
      // End of file as the first array element still counts.
      token_beat(ACT_RESTART, TOK_STRING),
      token_beat(ACT_FEED, TOK_OPEN_ARR), token_beat(ACT_FEED, TOK_EOF),
      token_beat(ACT_FEED, TOK_CLOSE_ARR),
      // Object holding an empty array.
      token_beat(ACT_RESTART, TOK_OPEN_OBJ),
      token_beat(ACT_FEED, TOK_OPEN_OBJ), token_beat(ACT_FEED, TOK_STRING),
      token_beat(ACT_FEED, TOK_COLON), token_beat(ACT_FEED, TOK_OPEN_ARR),
      token_beat(ACT_FEED, TOK_CLOSE_ARR), token_beat(ACT_FEED, TOK_CLOSE_OBJ),
      // Comma as the first array element, then sticky error and reserved codes.
      token_beat(ACT_RESTART, TOK_COLON),
      token_beat(ACT_FEED, TOK_OPEN_ARR), token_beat(ACT_FEED, TOK_COMMA),
      token_beat(ACT_FEED, TOK_RESERVED_LO),
      token_beat(ACT_RESTART, TOK_RESERVED_HI),
      token_beat(ACT_FEED, TOK_RESERVED_HI)
    };
    foreach (opening[i]) begin
      void'(walker.next_result(opening[i]));
      offer(opening[i]);
    end

    // Random phases, each at its own depth limit.
    limit_plan = '{6'd1, 6'd0, 6'd63, 6'd2, 6'd32, 6'd33, 6'd4, 6'd3};
    limit_plan[6] = 6'($urandom_range(4, 31));
    for (int p = 0; p < PHASES; p++) begin
      write_depth_limit(limit_plan[p]);
      bursty = (p % 2 == 0);
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        if (p % 3 == 2 && n == 40) long_hold_req = 1'b1;
        if (bursty && burst_left == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
          burst_left = $urandom_range(1, 24);
        end
        offer(next_token());
        if (burst_left > 0) burst_left--;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/jtsp_pkg.sv
rtl/core/jtsp_cell.sv
rtl/core/jtsp_ctrl.sv
rtl/core/json_token_structure_parser.sv
tb/tb.sv
